@@ hw/rtl/iprs_pkg.sv @@
// ----------------------------------------------------------------------------
// iprs_pkg
// Shared types and constants of the I/O request page segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package iprs_pkg;

    localparam int START_W = 48;
    localparam int COUNT_W = 8;
    localparam int NS_W    = 7;
    localparam int PAGE_W  = 46;
    localparam int BOFF_W  = 14;
    localparam int BLEN_W  = 15;
    localparam int MASK_W  = 4;

    localparam int SECTOR_SIZE_LOG2 = 12;

    localparam logic [COUNT_W-1:0] MAX_SECTORS = 8'd252;
    localparam int MAX_RESULTS = 64;
    localparam int RES_W       = 7;

    typedef struct packed {
        logic [START_W-1:0] start_sector;
        logic [COUNT_W-1:0] req_sectors;
        logic               is_read;
        logic [NS_W-1:0]    namespace_id;
    } t_req;

    typedef struct packed {
        logic [PAGE_W-1:0] logical_page;
        logic [BOFF_W-1:0] byte_offset;
        logic [BLEN_W-1:0] byte_length;
        logic [MASK_W-1:0] sector_mask;
        logic              txn_is_read;
        logic [NS_W-1:0]   txn_namespace;
        logic              last_txn;
    } t_txn;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic req_empty;
        logic div_done;
        logic last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ hw/rtl/iprs_stream_if.sv @@
// ----------------------------------------------------------------------------
// iprs_stream_if
// Valid/ready channels for requests and page transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface iprs_req_if
    import iprs_pkg::*;
();
    logic valid;
    logic ready;
    t_req payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

interface iprs_txn_if
    import iprs_pkg::*;
();
    logic valid;
    logic ready;
    t_txn payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/iprs_ctrl.sv @@
// ----------------------------------------------------------------------------
// iprs_ctrl
// Sequencer: accepts a request, waits for the page split, then walks pages.
// ----------------------------------------------------------------------------
`default_nettype none

module iprs_ctrl
    import iprs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_in_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    always_comb begin
        o_cmd.load     = r_in_ready && i_in_valid;
        o_cmd.div_step = (r_state == S_DIV) && !i_sts.div_done;
        o_cmd.emit     = (r_state == S_EMIT) && i_sts.out_free;
    end

    assign o_in_ready = r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.load && !i_sts.req_empty) begin
                        r_state    <= S_DIV;
                        r_in_ready <= 1'b0;
                    end else begin
                        r_in_ready <= 1'b1;
                    end
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (o_cmd.emit && i_sts.last) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/iprs_datapath.sv @@
// ----------------------------------------------------------------------------
// iprs_datapath
// Cursor, page/offset split, per-page transaction build and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iprs_datapath
    import iprs_pkg::*;
#(
    parameter int SECTORS_PER_PAGE = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    input  wire t_req i_req,
    input  wire logic i_out_ready,
    output logic      o_out_valid,
    output t_txn      o_out
);

    localparam int SPP      = SECTORS_PER_PAGE;
    localparam int SH       = $clog2(SPP);
    localparam int OFF_W    = (SPP > 1) ? $clog2(SPP) : 1;
    localparam int SZ_W     = $clog2(SPP + 1);
    localparam bit IS_POW2  = ((SPP & (SPP - 1)) == 0);
    localparam int DIG_W    = 12;
    localparam int DIG_N    = START_W / DIG_W;
    localparam int DV_W     = OFF_W + DIG_W;
    localparam int RCP_SH   = DV_W + OFF_W;
    localparam int RCP_W    = RCP_SH + 1;
    localparam int PRD_W    = DV_W + RCP_W;
    localparam int DIVCNT_W = $clog2(DIG_N + 1);

    localparam logic [RCP_W-1:0]     RCP       = RCP_W'((2 ** RCP_SH + SPP - 1) / SPP);
    localparam logic [DV_W-1:0]      SPP_DV    = DV_W'(SPP);
    localparam logic [SZ_W-1:0]      SPP_SZ    = SZ_W'(SPP);
    localparam logic [START_W-1:0]   OFF_MASK  = START_W'(SPP - 1);
    localparam logic [DIVCNT_W-1:0]  DIV_STEPS = DIVCNT_W'(DIG_N);
    localparam logic [RES_W-1:0]     LAST_IDX  = RES_W'(MAX_RESULTS - 1);

    logic [START_W-1:0]  r_cursor;
    logic [START_W-1:0]  r_quo;
    logic [OFF_W-1:0]    r_off;
    logic [COUNT_W-1:0]  r_left;
    logic [RES_W-1:0]    r_n;
    logic [DIVCNT_W-1:0] r_div_cnt;
    logic                r_dir;
    logic [NS_W-1:0]     r_ns;
    logic                r_out_valid;
    t_txn                r_out;

    logic [COUNT_W-1:0] w_count;
    logic [START_W-1:0] w_start_off;
    logic [DV_W-1:0]    w_dv;
    logic [PRD_W-1:0]   w_prd;
    logic [DIG_W-1:0]   w_qd;
    logic [DV_W-1:0]    w_back;
    logic [DV_W-1:0]    w_rem;
    logic [SZ_W-1:0]    w_room;
    logic [SZ_W-1:0]    w_size;
    logic [START_W:0]   w_sum;
    logic [COUNT_W-1:0] w_left_next;
    logic               w_last;
    logic [7:0]         w_lo;
    logic [7:0]         w_hi;
    logic [MASK_W-1:0]  w_mask;
    logic [31:0]        w_boff;
    logic [31:0]        w_blen;

    always_comb begin
        w_count     = (i_req.req_sectors > MAX_SECTORS) ? MAX_SECTORS : i_req.req_sectors;
        w_start_off = i_req.start_sector & OFF_MASK;

        // one 12-bit quotient digit of the split by the page size
        w_dv   = {r_off, r_quo[START_W-1 -: DIG_W]};
        w_prd  = PRD_W'(w_dv) * PRD_W'(RCP);
        w_qd   = w_prd[RCP_SH +: DIG_W];
        w_back = DV_W'(w_qd) * SPP_DV;
        w_rem  = w_dv - w_back;

        w_room = SPP_SZ - SZ_W'(r_off);
        if ({{(COUNT_W - SZ_W){1'b0}}, w_room} > r_left) begin
            w_size = r_left[SZ_W-1:0];
        end else begin
            w_size = w_room;
        end

        w_sum       = {1'b0, r_cursor} + (START_W + 1)'(w_size);
        w_left_next = r_left - COUNT_W'(w_size);
        w_last      = (w_left_next == '0) || (r_n == LAST_IDX);

        w_lo = 8'(r_off);
        w_hi = 8'(r_off) + 8'(w_size);
        for (int i = 0; i < MASK_W; i++) begin
            w_mask[i] = (8'(i) >= w_lo) && (8'(i) < w_hi);
        end

        w_boff = 32'(r_off) << SECTOR_SIZE_LOG2;
        w_blen = 32'(w_size) << SECTOR_SIZE_LOG2;
    end

    always_comb begin
        o_sts.req_empty = (i_req.req_sectors == '0);
        o_sts.div_done  = IS_POW2 || (r_div_cnt == DIV_STEPS);
        o_sts.last      = w_last;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cursor  <= i_req.start_sector;
            r_left    <= w_count;
            r_n       <= '0;
            r_dir     <= i_req.is_read;
            r_ns      <= i_req.namespace_id;
            r_div_cnt <= '0;
            if (IS_POW2) begin
                r_quo <= i_req.start_sector >> SH;
                r_off <= w_start_off[OFF_W-1:0];
            end else begin
                r_quo <= i_req.start_sector;
                r_off <= '0;
            end
        end else if (i_cmd.div_step) begin
            r_quo     <= {r_quo[START_W-DIG_W-1:0], w_qd};
            r_off     <= w_rem[OFF_W-1:0];
            r_div_cnt <= r_div_cnt + 1'b1;
        end else if (i_cmd.emit) begin
            r_cursor <= w_sum[START_W-1:0];
            r_left   <= w_left_next;
            r_n      <= r_n + 1'b1;
            // wrap of the sector address lands inside page zero
            if (w_sum[START_W]) begin
                r_quo <= '0;
                r_off <= w_sum[OFF_W-1:0];
            end else begin
                r_quo <= r_quo + 1'b1;
                r_off <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.logical_page  <= r_quo[PAGE_W-1:0];
            r_out.byte_offset   <= w_boff[BOFF_W-1:0];
            r_out.byte_length   <= w_blen[BLEN_W-1:0];
            r_out.sector_mask   <= w_mask;
            r_out.txn_is_read   <= r_dir;
            r_out.txn_namespace <= r_ns;
            r_out.last_txn      <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

@@ hw/rtl/io_request_page_segmenter_top.sv @@
// ----------------------------------------------------------------------------
// io_request_page_segmenter_top
// Splits one host I/O request into one transaction per touched flash page.
// sequence: after accept the start sector is split into page and offset (by shift if
//   SECTORS_PER_PAGE is a power of two, else in 12-bit digits), then pages are emitted
// throughput: one transaction per cycle while the output is not stalled; the next
//   request is taken once the last transaction of the current one is registered
// reset: synchronous active low; clears the sequencer and output valid
// ----------------------------------------------------------------------------
`default_nettype none

module io_request_page_segmenter_top
    import iprs_pkg::*;
#(
    parameter int SECTORS_PER_PAGE = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    iprs_req_if.sink    i_req,
    iprs_txn_if.source  o_txn
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic w_out_valid;
    t_txn w_out;

    iprs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    iprs_datapath #(
        .SECTORS_PER_PAGE (SECTORS_PER_PAGE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req       (i_req.payload),
        .i_out_ready (o_txn.ready),
        .o_out_valid (w_out_valid),
        .o_out       (w_out)
    );

    assign i_req.ready   = w_in_ready;
    assign o_txn.valid   = w_out_valid;
    assign o_txn.payload = w_out;

endmodule

`default_nettype wire

@@ hw/rtl/iprs_checker.sv @@
// ----------------------------------------------------------------------------
// iprs_checker
// Port-level checks of the request page segmenter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iprs_checker
    import iprs_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire t_req i_in_req,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire t_txn i_out_txn
);

    // stalled transaction holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_txn))
        else $error("transaction changed while stalled");

    // reset empties the output
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a non-empty request blocks the input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_req.req_sectors != '0) |=> !i_in_ready)
        else $error("request taken while another is in progress");

    // no new request while a non-last transaction is at the output
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_txn.last_txn |-> !i_in_ready)
        else $error("input ready in the middle of a request");

endmodule

bind io_request_page_segmenter_top iprs_checker u_iprs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_req    (i_req.payload),
    .i_out_valid (o_txn.valid),
    .i_out_ready (o_txn.ready),
    .i_out_txn   (o_txn.payload)
);

`default_nettype wire
